// File: sv/word_boundary_prefix_matcher_top_macros.svh
// ------------------------------------------------------------------------
// Word boundary prefix matcher: assertion macros
// Shared property forms for the checker, sampled on clk_i, off in reset.
// ------------------------------------------------------------------------
`ifndef WORD_BOUNDARY_PREFIX_MATCHER_TOP_MACROS_SVH
`define WORD_BOUNDARY_PREFIX_MATCHER_TOP_MACROS_SVH

// Same-cycle implication.
`define WBPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define WBPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/wbpm_pkg.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// wbpm_pkg
// Sizes, register indexes, cell control and byte helpers of the matcher.
// ------------------------------------------------------------------------
package wbpm_pkg;

  localparam int MAX_PREFIX    = 16;
  localparam int POSITION_BITS = 16;
  // Bytes held by the two 64-bit prefix registers.
  localparam int REG_BYTES     = 16;
  localparam int LEN_W         = $clog2(MAX_PREFIX + 1);
  localparam int OFFSET_W      = 16;

  localparam logic [7:0] ASCII_TOP = 8'h7F;

  typedef enum logic [1:0] {
    CFG_PREFIX_LENGTH = 2'd0,
    CFG_PREFIX_LOW    = 2'd1,
    CFG_PREFIX_HIGH   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic advance;  // a word is taken this cycle
    logic clear;    // that word ends the candidate
  } cell_ctl_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

endpackage

// File: sv/wbpm_cell.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// wbpm_cell
// One prefix position: holds whether an attempt has matched this many
// bytes and hands the result of the current byte to its right neighbor.
// ------------------------------------------------------------------------
module wbpm_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wbpm_pkg::cell_ctl_t ctl_i,
  input  logic [7:0]        cand_i,   // folded candidate byte
  input  logic [7:0]        pref_i,   // folded prefix byte of this position
  input  logic              start_i,  // an attempt may open here
  input  logic              left_i,   // hand-off from the left neighbor
  input  logic              body_i,   // more prefix bytes follow this one
  input  logic              tail_i,   // this is the last prefix byte
  output logic              hand_o,
  output logic              hit_o
);
  import wbpm_pkg::*;

  logic active_q, active_d;
  logic active, match;

  assign active = active_q | start_i;
  assign match  = active & (cand_i == pref_i);
  assign hand_o = match & body_i;
  assign hit_o  = match & tail_i;

  always_comb begin
    active_d = active_q;
    if (ctl_i.advance) begin
      active_d = ctl_i.clear ? 1'b0 : left_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

endmodule

// File: sv/word_boundary_prefix_matcher_top.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// word_boundary_prefix_matcher_top
// Case-folded search for a configured prefix at word boundaries of a
// candidate string streamed one byte per word.
// ------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  in        sink       in_valid_i/in_ready_o   cand_byte_i, is_last_i
//  out       source     out_valid_o/out_ready_i found_o, match_offset_o,
//                                               overflow_o
//  cfg       sink       cfg_we_i (no wait)      cfg_index_i, cfg_wdata_i
//
//  One byte per cycle unless a last byte is held: each byte passes the whole row of
//  MAX_PREFIX cells in the cycle it is taken.
//  The result of a last byte is loaded into the output register as the byte is taken.
//  Reset leaves the block ready at once; there is no clearing pass.
//  While a result waits, non-last bytes keep flowing; only the next last
//  byte is held until the output register frees up.
// ------------------------------------------------------------------------
module word_boundary_prefix_matcher_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    cand_byte_i,
  input  logic                          is_last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          found_o,
  output logic [wbpm_pkg::OFFSET_W-1:0] match_offset_o,
  output logic                          overflow_o,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [63:0]                   cfg_wdata_i
);
  import wbpm_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  // Configuration: prefix bytes are stored already folded.
  logic [4:0]                prefix_length_q;
  logic [REG_BYTES-1:0][7:0] prefix_q;

  // Candidate state.
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic                     ovf_q, ovf_d;
  logic                     seen_q, seen_d;
  logic [POSITION_BITS-1:0] first_q, first_d;
  logic                     boundary_q, boundary_d;

  // Output register.
  logic                out_valid_q;
  logic                found_q;
  logic [OFFSET_W-1:0] offset_q;
  logic                out_ovf_q;

  logic                  accept, take_last;
  logic [LEN_W-1:0]      len;
  logic [7:0]            cand_fold;
  cell_ctl_t             ctl;
  logic [MAX_PREFIX-1:0] hand, hit, body, tail;
  logic                  hit_any, empty_hit;

  // Hold a last byte only while an unread result blocks the output slot.
  assign in_ready_o = !(out_valid_q && !out_ready_i) || !is_last_i;
  assign accept     = in_valid_i && in_ready_o;
  assign take_last  = accept && is_last_i;

  assign cand_fold   = fold_case(cand_byte_i);
  assign ctl.advance = accept;
  assign ctl.clear   = is_last_i;

  // Clamp the length register to the row size.
  always_comb begin
    if (32'(prefix_length_q) > MAX_PREFIX) begin
      len = LEN_W'(MAX_PREFIX);
    end else begin
      len = LEN_W'(prefix_length_q);
    end
  end

  // Row of cells: cell k tracks attempts that have matched k bytes.
  for (genvar k = 0; k < MAX_PREFIX; k++) begin : g_cell
    logic [7:0] pref;
    logic       left;
    logic       start;

    if (k < REG_BYTES) begin : g_reg
      assign pref = prefix_q[k];
    end else begin : g_zero
      assign pref = 8'h00;
    end

    if (k == 0) begin : g_head
      assign left  = 1'b0;
      assign start = boundary_q;
    end else begin : g_link
      assign left  = hand[k-1];
      assign start = 1'b0;
    end

    assign body[k] = len > LEN_W'(k + 1);
    assign tail[k] = len == LEN_W'(k + 1);

    wbpm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .cand_i  (cand_fold),
      .pref_i  (pref),
      .start_i (start),
      .left_i  (left),
      .body_i  (body[k]),
      .tail_i  (tail[k]),
      .hand_o  (hand[k]),
      .hit_o   (hit[k])
    );
  end

  // Only the cell at the prefix end can complete, so at most one hit.
  assign hit_any   = |hit;
  assign empty_hit = (len == '0) && (pos_q == '0);

  always_comb begin
    pos_d      = pos_q;
    ovf_d      = ovf_q;
    seen_d     = seen_q;
    first_d    = first_q;
    boundary_d = boundary_q;
    if (accept) begin
      // Saturate the position and flag the candidate.
      if (pos_q == POS_MAX) begin
        ovf_d = 1'b1;
      end else begin
        pos_d = pos_q + 1'b1;
      end
      // Keep only the earliest completed start.
      if (!seen_q && (hit_any || empty_hit)) begin
        seen_d = 1'b1;
        if (empty_hit) begin
          first_d = '0;
        end else begin
          first_d = pos_q - POSITION_BITS'(len) + 1'b1;
        end
      end
      boundary_d = (cand_byte_i <= ASCII_TOP) && !is_alnum(cand_byte_i);
    end
  end

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_length_q <= '0;
      prefix_q        <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PREFIX_LENGTH: prefix_length_q <= cfg_wdata_i[4:0];
        CFG_PREFIX_LOW: begin
          for (int j = 0; j < 8; j++) begin
            prefix_q[j] <= fold_case(cfg_wdata_i[8*j +: 8]);
          end
        end
        CFG_PREFIX_HIGH: begin
          for (int j = 0; j < 8; j++) begin
            prefix_q[j+8] <= fold_case(cfg_wdata_i[8*j +: 8]);
          end
        end
        default: ;
      endcase
    end
  end

  // Candidate state: return to the start values after a last byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      ovf_q      <= 1'b0;
      seen_q     <= 1'b0;
      first_q    <= '0;
      boundary_q <= 1'b1;
    end else if (take_last) begin
      pos_q      <= '0;
      ovf_q      <= 1'b0;
      seen_q     <= 1'b0;
      first_q    <= '0;
      boundary_q <= 1'b1;
    end else begin
      pos_q      <= pos_d;
      ovf_q      <= ovf_d;
      seen_q     <= seen_d;
      first_q    <= first_d;
      boundary_q <= boundary_d;
    end
  end

  // Output register: load on a last byte, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_last) begin
      found_q   <= seen_d;
      offset_q  <= seen_d ? OFFSET_W'(first_d) : '0;
      out_ovf_q <= ovf_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign match_offset_o = offset_q;
  assign overflow_o     = out_ovf_q;

endmodule

// File: sv/wbpm_checker.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// wbpm_checker
// Port-level checks of the matcher, bound to the top level.
// ------------------------------------------------------------------------
`include "word_boundary_prefix_matcher_top_macros.svh"

module wbpm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          is_last_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          found_o,
  input logic [wbpm_pkg::OFFSET_W-1:0] match_offset_o,
  input logic                          overflow_o
);
  import wbpm_pkg::*;

  // A stalled result holds its value.
  `WBPM_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(found_o) && $stable(match_offset_o) && $stable(overflow_o),
    "result changed while stalled")

  // No match reports offset zero.
  `WBPM_ASSERT_NOW(a_miss_zero, out_valid_o && !found_o, match_offset_o == '0,
    "offset set without a match")

  // A taken last byte yields a result next cycle.
  `WBPM_ASSERT_NEXT(a_last_result, in_valid_i && in_ready_o && is_last_i, out_valid_o,
    "last byte gave no result")

  // A non-last byte never creates a result.
  `WBPM_ASSERT_NEXT(a_mid_silent,
    in_valid_i && in_ready_o && !is_last_i && !out_valid_o, !out_valid_o,
    "result without a last byte")

  // A last byte is held while the output slot is blocked.
  `WBPM_ASSERT_NOW(a_last_held, out_valid_o && !out_ready_i && is_last_i, !in_ready_o,
    "last byte taken into a full slot")

endmodule

bind word_boundary_prefix_matcher_top wbpm_checker u_wbpm_checker (.*);
